// File: design/qtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qtt_pkg;

    // Token kind codes carried on the result channel.
    localparam logic [4:0] K_END    = 5'd0;
    localparam logic [4:0] K_ERROR  = 5'd1;
    localparam logic [4:0] K_VAR    = 5'd2;
    localparam logic [4:0] K_IRI    = 5'd3;
    localparam logic [4:0] K_IDENT  = 5'd4;
    localparam logic [4:0] K_STRING = 5'd5;
    localparam logic [4:0] K_NUMBER = 5'd6;
    localparam logic [4:0] K_DOT    = 5'd7;
    localparam logic [4:0] K_LCURLY = 5'd8;
    localparam logic [4:0] K_RCURLY = 5'd9;
    localparam logic [4:0] K_LROUND = 5'd10;
    localparam logic [4:0] K_RROUND = 5'd11;
    localparam logic [4:0] K_EQ     = 5'd12;
    localparam logic [4:0] K_NE     = 5'd13;
    localparam logic [4:0] K_LT     = 5'd14;
    localparam logic [4:0] K_LE     = 5'd15;
    localparam logic [4:0] K_GT     = 5'd16;
    localparam logic [4:0] K_GE     = 5'd17;

    // One token as it sits in the result queue.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// File: design/query_text_tokenizer.sv
// The tokens of a character are written into the registered result queue at its transfer.
// Throughput: one character per cycle while each character yields at most one token and
// the output is not stalled; the input is held off while the 4-entry result queue holds
// more than one entry, so after a character with two or three tokens the drain rate rules.
// Reset (synchronous, active low) empties the result queue, sets the scanner idle
// and clears the offsets and the error flag.
`timescale 1ns / 1ps
`default_nettype none

module query_text_tokenizer
    import qtt_pkg::*;
#(
    parameter int MAX_QUERY_LEN = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_final_char,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run
);

    localparam int POS_W = $clog2(MAX_QUERY_LEN + 1);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 16;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_QUERY_LEN);

    // Scanner modes.
    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUM_INT  = 4'd2;
    localparam logic [3:0] M_NUM_FRAC = 4'd3;
    localparam logic [3:0] M_STRING   = 4'd4;
    localparam logic [3:0] M_VAR      = 4'd5;
    localparam logic [3:0] M_GT       = 4'd6;
    localparam logic [3:0] M_LT       = 4'd7;
    localparam logic [3:0] M_IRI      = 4'd8;
    localparam logic [3:0] M_BANG     = 4'd9;

    // Character codes.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_USCORE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return (w > EXT_W'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    // Scanner state.
    logic [3:0]       r_mode, n_mode;
    logic [POS_W-1:0] r_org, n_org;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_err_seen, n_err_seen;

    // Result queue.
    t_result    r_fifo [4];
    logic [1:0] r_head;
    logic [2:0] r_count, n_count;
    logic [1:0] tail;

    logic in_fire, out_fire;

    // Token candidates for the current character, in output order.
    logic             a_v, b_v, c_v, d_v, e_v;
    logic [4:0]       a_kind, b_kind, c_kind;
    logic [POS_W-1:0] a_stop;
    logic [POS_W-1:0] pos_next, org;
    logic             used, err;

    t_result    slot [3];
    logic [1:0] push_n;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = o_out_valid && !i_out_stall;
    assign pos_next = (r_pos < MAX_POS) ? r_pos + POS_W'(1) : MAX_POS;

    // Per-character scan: pending token first, then a new token, then the flush.
    always_comb begin
        n_mode     = r_mode;
        n_org      = r_org;
        n_pos      = pos_next;
        n_err_seen = r_err_seen;
        used       = 1'b0;
        err        = 1'b0;
        org        = r_org;
        a_v        = 1'b0;
        a_kind     = K_IDENT;
        a_stop     = r_pos;
        b_v        = 1'b0;
        b_kind     = K_DOT;
        c_v        = 1'b0;
        c_kind     = K_IDENT;
        d_v        = 1'b0;
        e_v        = 1'b0;

        if (!r_err_seen) begin
            unique case (r_mode)
                M_IDENT, M_VAR: begin
                    if (is_word(i_char_code)) begin
                        used = 1'b1;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = (r_mode == M_VAR) ? K_VAR : K_IDENT;
                        n_mode = M_IDLE;
                    end
                end
                M_NUM_INT: begin
                    if (is_digit(i_char_code)) begin
                        used = 1'b1;
                    end else if (i_char_code == CH_DOT) begin
                        used   = 1'b1;
                        n_mode = M_NUM_FRAC;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = K_NUMBER;
                        n_mode = M_IDLE;
                    end
                end
                M_NUM_FRAC: begin
                    if (is_digit(i_char_code)) begin
                        used = 1'b1;
                    end else begin
                        a_v    = 1'b1;
                        a_kind = K_NUMBER;
                        n_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    used = 1'b1;
                    if (i_char_code == CH_QUOTE) begin
                        a_v    = 1'b1;
                        a_kind = K_STRING;
                        a_stop = pos_next;
                        n_mode = M_IDLE;
                    end
                end
                M_GT: begin
                    a_v = 1'b1;
                    if (i_char_code == CH_EQ) begin
                        used   = 1'b1;
                        a_kind = K_GE;
                        a_stop = pos_next;
                    end else begin
                        a_kind = K_GT;
                    end
                    n_mode = M_IDLE;
                end
                M_LT: begin
                    if (i_char_code == CH_SP) begin
                        a_v    = 1'b1;
                        a_kind = K_LT;
                        n_mode = M_IDLE;
                    end else if (i_char_code == CH_EQ) begin
                        used   = 1'b1;
                        a_v    = 1'b1;
                        a_kind = K_LE;
                        a_stop = pos_next;
                        n_mode = M_IDLE;
                    end else if (is_blank(i_char_code)) begin
                        err = 1'b1;
                    end else if (i_char_code == CH_GT) begin
                        used   = 1'b1;
                        a_v    = 1'b1;
                        a_kind = K_IRI;
                        a_stop = pos_next;
                        n_mode = M_IDLE;
                    end else begin
                        used   = 1'b1;
                        n_mode = M_IRI;
                    end
                end
                M_IRI: begin
                    if (is_blank(i_char_code)) begin
                        err = 1'b1;
                    end else begin
                        used = 1'b1;
                        if (i_char_code == CH_GT) begin
                            a_v    = 1'b1;
                            a_kind = K_IRI;
                            a_stop = pos_next;
                            n_mode = M_IDLE;
                        end
                    end
                end
                M_BANG: begin
                    if (i_char_code == CH_EQ) begin
                        used   = 1'b1;
                        a_v    = 1'b1;
                        a_kind = K_NE;
                        a_stop = pos_next;
                        n_mode = M_IDLE;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase

            // A character not taken by the pending token starts a new one.
            if (!err && !used) begin
                case (i_char_code) inside
                    CH_SP, CH_TAB, CH_LF, CH_CR: ;
                    CH_LBRACE: begin b_v = 1'b1; b_kind = K_LCURLY; end
                    CH_RBRACE: begin b_v = 1'b1; b_kind = K_RCURLY; end
                    CH_LPAR:   begin b_v = 1'b1; b_kind = K_LROUND; end
                    CH_RPAR:   begin b_v = 1'b1; b_kind = K_RROUND; end
                    CH_DOT:    begin b_v = 1'b1; b_kind = K_DOT; end
                    CH_EQ:     begin b_v = 1'b1; b_kind = K_EQ; end
                    CH_QUOTE:  n_mode = M_STRING;
                    CH_QMARK:  n_mode = M_VAR;
                    CH_GT:     n_mode = M_GT;
                    CH_LT:     n_mode = M_LT;
                    CH_BANG:   n_mode = M_BANG;
                    default:   n_mode = is_digit(i_char_code) ? M_NUM_INT : M_IDENT;
                endcase
                n_org = r_pos;
                org   = r_pos;
            end

            // The final char flushes or errs on the pending token and closes the query.
            if (!err && i_final_char) begin
                unique case (n_mode)
                    M_IDENT:              begin c_v = 1'b1; c_kind = K_IDENT; end
                    M_VAR:                begin c_v = 1'b1; c_kind = K_VAR; end
                    M_NUM_INT, M_NUM_FRAC: begin c_v = 1'b1; c_kind = K_NUMBER; end
                    M_GT:                 begin c_v = 1'b1; c_kind = K_GT; end
                    M_IDLE:               ;
                    default:              err = 1'b1;
                endcase
                d_v = !err;
            end

            if (err) begin
                e_v        = 1'b1;
                n_err_seen = 1'b1;
            end
        end

        if (i_final_char) begin
            n_mode     = M_IDLE;
            n_org      = '0;
            n_pos      = '0;
            n_err_seen = 1'b0;
        end
    end

    // Pack the candidate tokens into consecutive slots.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            slot[k] = '0;
        end
        push_n = 2'd0;
        if (a_v) begin
            slot[push_n] = '{kind: a_kind, start: sat16(r_org),
                             length: sat16(a_stop - r_org), last: 1'b0};
            push_n = push_n + 2'd1;
        end
        if (b_v) begin
            slot[push_n] = '{kind: b_kind, start: sat16(r_pos),
                             length: sat16(pos_next - r_pos), last: 1'b0};
            push_n = push_n + 2'd1;
        end
        if (c_v && push_n < 2'd3) begin
            slot[push_n] = '{kind: c_kind, start: sat16(org),
                             length: sat16(pos_next - org), last: 1'b0};
            push_n = push_n + 2'd1;
        end
        if (d_v && push_n < 2'd3) begin
            slot[push_n] = '{kind: K_END, start: sat16(pos_next),
                             length: 16'd0, last: 1'b0};
            push_n = push_n + 2'd1;
        end
        if (e_v && push_n < 2'd3) begin
            slot[push_n] = '{kind: K_ERROR, start: sat16(org),
                             length: sat16(pos_next - org), last: 1'b0};
            push_n = push_n + 2'd1;
        end
        if (push_n != 2'd0) begin
            slot[push_n - 2'd1].last = 1'b1;
        end
    end

    // Queue occupancy after this cycle's pushes and pop.
    assign tail    = r_head + r_count[1:0];
    assign n_count = r_count + (in_fire ? {1'b0, push_n} : 3'd0) - {2'b0, out_fire};

    // Scanner state update on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_org      <= '0;
            r_pos      <= '0;
            r_err_seen <= 1'b0;
        end else if (in_fire) begin
            r_mode     <= n_mode;
            r_org      <= n_org;
            r_pos      <= n_pos;
            r_err_seen <= n_err_seen;
        end
    end

    // Queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
            if (out_fire) begin
                r_head <= r_head + 2'd1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < push_n) begin
                    r_fifo[tail + 2'(k)] <= slot[k];
                end
            end
        end
    end

    // Room for the three tokens one character can yield.
    assign o_in_stall     = (r_count > 3'd1);
    assign o_out_valid    = (r_count != 3'd0);
    assign o_token_kind   = r_fifo[r_head].kind;
    assign o_token_start  = r_fifo[r_head].start;
    assign o_token_length = r_fifo[r_head].length;
    assign o_last_of_run  = r_fifo[r_head].last;

endmodule

`default_nettype wire

// File: design/qtt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module qtt_checker
    import qtt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [4:0]  o_token_kind,
    input wire logic [15:0] o_token_start,
    input wire logic [15:0] o_token_length,
    input wire logic        o_last_of_run
);

    // With no tokens waiting, the input side is always open.
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while no token is waiting");

    // A stalled token stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("token withdrawn under stall");

    // A stalled token keeps its fields.
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_token_kind) && $stable(o_token_start)
            && $stable(o_token_length) && $stable(o_last_of_run))
        else $error("token fields changed under stall");

    // Only defined kinds leave the block.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_token_kind <= K_GE)
        else $error("undefined token kind");

    // End and error tokens close a character's run; an end token is empty.
    a_closing_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == K_END || o_token_kind == K_ERROR)
            |-> o_last_of_run && (o_token_kind != K_END || o_token_length == 16'd0))
        else $error("end or error token not last, or end token not empty");

endmodule

bind query_text_tokenizer qtt_checker u_qtt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_token_kind   (o_token_kind),
    .o_token_start  (o_token_start),
    .o_token_length (o_token_length),
    .o_last_of_run  (o_last_of_run)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import qtt_pkg::*;

    localparam int MAX_QUERY_LEN  = 65535;
    localparam int DIRECTED_ITEMS = 28;
    localparam int RANDOM_ITEMS   = 260;
    localparam int QUIET_ITEMS    = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int REPORT_LIMIT   = 40;

    // Bytes that carry a role in the query language.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LROUND = 8'h28;
    localparam logic [7:0] CH_RROUND = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    // Scanner modes of the predictor.
    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUM_INT,
        SCAN_NUM_FRAC,
        SCAN_STRING,
        SCAN_VAR,
        SCAN_GT,
        SCAN_LT,
        SCAN_IRI,
        SCAN_BANG
    } scan_mode_e;

    // Predicts the tokens of each accepted character and checks the token stream.
    class token_scoreboard;
        t_result     expected_tokens[$];
        t_result     step_tokens[$];
        scan_mode_e  mode;
        int unsigned origin;
        int unsigned position;
        bit          in_error;
        int unsigned scanned_chars;
        int unsigned fail_count;

        function new();
            clear_scan();
            scanned_chars = 0;
            fail_count = 0;
        endfunction

        function void clear_scan();
            mode = SCAN_IDLE;
            origin = 0;
            position = 0;
            in_error = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_word(logic [7:0] c);
            return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                || c == CH_USCORE;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
        endfunction

        function logic [15:0] sat16(int unsigned v);
            return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
        endfunction

        // At most three tokens come out of one character.
        function void add_token(logic [4:0] kind, int unsigned from, int unsigned upto);
            t_result tok;
            if (step_tokens.size() >= 3) return;
            tok.kind   = kind;
            tok.start  = sat16(from);
            tok.length = sat16(upto >= from ? upto - from : 0);
            tok.last   = 1'b0;
            step_tokens.push_back(tok);
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void note_char(logic [7:0] c, logic fin);
            int unsigned pos;
            int unsigned nxt;
            int unsigned org;
            bit used;
            bit err;
            pos = position;
            nxt = (pos < MAX_QUERY_LEN) ? pos + 1 : MAX_QUERY_LEN;
            org = origin;
            used = 1'b0;
            err = 1'b0;
            step_tokens.delete();

            // After an error everything up to the final character is dropped.
            if (in_error) begin
                if (fin) begin
                    clear_scan();
                end else begin
                    position = nxt;
                end
                return;
            end
            scanned_chars++;

            // The pending token gets the first look at the character.
            case (mode)
                SCAN_IDENT, SCAN_VAR: begin
                    if (is_word(c)) begin
                        used = 1'b1;
                    end else begin
                        add_token(mode == SCAN_VAR ? K_VAR : K_IDENT, org, pos);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_NUM_INT: begin
                    if (is_digit(c)) begin
                        used = 1'b1;
                    end else if (c == CH_DOT) begin
                        used = 1'b1;
                        mode = SCAN_NUM_FRAC;
                    end else begin
                        add_token(K_NUMBER, org, pos);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_NUM_FRAC: begin
                    if (is_digit(c)) begin
                        used = 1'b1;
                    end else begin
                        add_token(K_NUMBER, org, pos);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_STRING: begin
                    used = 1'b1;
                    if (c == CH_QUOTE) begin
                        add_token(K_STRING, org, nxt);
                        mode = SCAN_IDLE;
                    end
                end
                SCAN_GT: begin
                    if (c == CH_EQ) begin
                        used = 1'b1;
                        add_token(K_GE, org, nxt);
                    end else begin
                        add_token(K_GT, org, pos);
                    end
                    mode = SCAN_IDLE;
                end
                SCAN_LT: begin
                    if (c == CH_SPACE) begin
                        add_token(K_LT, org, pos);
                        mode = SCAN_IDLE;
                    end else if (c == CH_EQ) begin
                        used = 1'b1;
                        add_token(K_LE, org, nxt);
                        mode = SCAN_IDLE;
                    end else if (is_blank(c)) begin
                        err = 1'b1;
                    end else if (c == CH_GT) begin
                        used = 1'b1;
                        add_token(K_IRI, org, nxt);
                        mode = SCAN_IDLE;
                    end else begin
                        used = 1'b1;
                        mode = SCAN_IRI;
                    end
                end
                SCAN_IRI: begin
                    if (is_blank(c)) begin
                        err = 1'b1;
                    end else begin
                        used = 1'b1;
                        if (c == CH_GT) begin
                            add_token(K_IRI, org, nxt);
                            mode = SCAN_IDLE;
                        end
                    end
                end
                SCAN_BANG: begin
                    if (c == CH_EQ) begin
                        used = 1'b1;
                        add_token(K_NE, org, nxt);
                        mode = SCAN_IDLE;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: mode = SCAN_IDLE;
            endcase

            // A character not taken by the pending token starts a new one.
            if (!err && !used) begin
                case (c)
                    CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                    CH_LCURLY: add_token(K_LCURLY, pos, nxt);
                    CH_RCURLY: add_token(K_RCURLY, pos, nxt);
                    CH_LROUND: add_token(K_LROUND, pos, nxt);
                    CH_RROUND: add_token(K_RROUND, pos, nxt);
                    CH_DOT:    add_token(K_DOT, pos, nxt);
                    CH_EQ:     add_token(K_EQ, pos, nxt);
                    CH_QUOTE:  mode = SCAN_STRING;
                    CH_QMARK:  mode = SCAN_VAR;
                    CH_GT:     mode = SCAN_GT;
                    CH_LT:     mode = SCAN_LT;
                    CH_BANG:   mode = SCAN_BANG;
                    default:   mode = is_digit(c) ? SCAN_NUM_INT : SCAN_IDENT;
                endcase
                origin = pos;
                org = pos;
            end

            // The final char flushes or errs on a pending token and closes the query.
            if (!err && fin) begin
                case (mode)
                    SCAN_IDLE: ;
                    SCAN_IDENT: add_token(K_IDENT, org, nxt);
                    SCAN_VAR: add_token(K_VAR, org, nxt);
                    SCAN_NUM_INT, SCAN_NUM_FRAC: add_token(K_NUMBER, org, nxt);
                    SCAN_GT: add_token(K_GT, org, nxt);
                    default: err = 1'b1;
                endcase
                if (!err) add_token(K_END, nxt, nxt);
            end

            if (err) begin
                add_token(K_ERROR, org, nxt);
                in_error = 1'b1;
            end

            if (fin) begin
                clear_scan();
            end else begin
                position = nxt;
            end

            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_token(t_result got);
            t_result want;
            if (expected_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $error("token with none expected: kind %0d start %0d length %0d",
                        got.kind, got.start, got.length);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind) report("token_kind", want.kind, got.kind);
            if (got.start !== want.start) report("token_start", want.start, got.start);
            if (got.length !== want.length) report("token_length", want.length, got.length);
            if (got.last !== want.last) report("last_of_run", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_char_code;
    logic        i_final_char;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [4:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    token_scoreboard scoreboard = new();
    logic [7:0]      query_text[$];
    bit              idle_enable = 1'b1;

    query_text_tokenizer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_final_char   (i_final_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Character generators for the random queries.
    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        int unsigned r;
        r = $urandom_range(0, 62);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h61 + r - 10);
        if (r < 62) return 8'(8'h41 + r - 36);
        return CH_USCORE;
    endfunction

    function automatic bit has_role(logic [7:0] c);
        return scoreboard.is_blank(c) || scoreboard.is_digit(c) || c == CH_LCURLY
            || c == CH_RCURLY || c == CH_LROUND || c == CH_RROUND || c == CH_DOT
            || c == CH_EQ || c == CH_QUOTE || c == CH_QMARK || c == CH_GT
            || c == CH_LT || c == CH_BANG;
    endfunction

    // Any byte without a role opens an identifier, high bytes and NUL included.
    function automatic logic [7:0] ident_start();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0) begin
            do c = word_char(); while (scoreboard.is_digit(c));
        end else begin
            do c = 8'($urandom_range(0, 255)); while (has_role(c));
        end
        return c;
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] iri_char(bit first);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (scoreboard.is_blank(c) || c == CH_GT || (first && c == CH_EQ));
        return c;
    endfunction

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) query_text.push_back(s[i]);
    endfunction

    // One well-formed token with random content.
    function automatic void add_token();
        int unsigned n;
        case ($urandom_range(0, 8))
            0, 1: begin
                query_text.push_back(ident_start());
                repeat ($urandom_range(0, 5)) query_text.push_back(word_char());
            end
            2: begin
                query_text.push_back(CH_QMARK);
                repeat ($urandom_range(0, 4)) query_text.push_back(word_char());
            end
            3: begin
                repeat ($urandom_range(1, 4))
                    query_text.push_back(8'(8'h30 + $urandom_range(0, 9)));
                if ($urandom_range(0, 1) == 1) begin
                    query_text.push_back(CH_DOT);
                    repeat ($urandom_range(0, 3))
                        query_text.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
            end
            4: begin
                query_text.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5)) query_text.push_back(string_char());
                query_text.push_back(CH_QUOTE);
            end
            5: begin
                n = $urandom_range(0, 5);
                query_text.push_back(CH_LT);
                for (int i = 0; i < n; i++) query_text.push_back(iri_char(i == 0));
                query_text.push_back(CH_GT);
            end
            6: begin
                case ($urandom_range(0, 5))
                    0: query_text.push_back(CH_LCURLY);
                    1: query_text.push_back(CH_RCURLY);
                    2: query_text.push_back(CH_LROUND);
                    3: query_text.push_back(CH_RROUND);
                    4: query_text.push_back(CH_DOT);
                    default: query_text.push_back(CH_EQ);
                endcase
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: append_text("<=");
                    1: append_text("< ");
                    2: append_text(">=");
                    3: append_text(">");
                    default: append_text("!=");
                endcase
            end
        endcase
    endfunction

    // A piece that raises an error in the middle of a query, or plain noise.
    function automatic void add_broken();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: begin
                query_text.push_back(CH_BANG);
                do c = 8'($urandom_range(0, 255)); while (c == CH_EQ);
                query_text.push_back(c);
            end
            1: begin
                query_text.push_back(CH_LT);
                do c = blank_char(); while (c == CH_SPACE);
                query_text.push_back(c);
            end
            2: begin
                query_text.push_back(CH_LT);
                repeat ($urandom_range(1, 4)) query_text.push_back(iri_char(1'b1));
                query_text.push_back(blank_char());
            end
            default: begin
                repeat ($urandom_range(1, 6)) query_text.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // A token left open by the final character.
    function automatic void add_unfinished();
        case ($urandom_range(0, 3))
            0: begin
                query_text.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 4)) query_text.push_back(string_char());
            end
            1: begin
                query_text.push_back(CH_LT);
                query_text.push_back(iri_char(1'b1));
                repeat ($urandom_range(0, 3)) query_text.push_back(iri_char(1'b0));
            end
            2: query_text.push_back(CH_LT);
            default: query_text.push_back(CH_BANG);
        endcase
    endfunction

    function automatic void build_query();
        int unsigned shape;
        query_text.delete();
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            repeat ($urandom_range(1, 3)) query_text.push_back(blank_char());
            return;
        end
        repeat ($urandom_range(1, 8)) begin
            add_token();
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 2)) query_text.push_back(blank_char());
        end
        if (shape <= 3) begin
            add_broken();
            repeat ($urandom_range(0, 2)) add_token();
        end else if (shape <= 6) begin
            add_unfinished();
        end
    endfunction

    // One character transfer, with an optional idle burst in front of it.
    task automatic send_char(input logic [7:0] code, input logic fin);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_code  <= code;
        i_final_char <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_query();
        for (int i = 0; i < query_text.size(); i++)
            send_char(query_text[i], i == query_text.size() - 1);
    endtask

    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending() != 0) @(posedge i_clk);
    endtask

    // Random stall bursts on the token side.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Both transfers are observed at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            scoreboard.note_char(i_char_code, i_final_char);
        if (i_rst_n && o_out_valid && !i_out_stall)
            scoreboard.check_token('{kind: o_token_kind, start: o_token_start,
                length: o_token_length, last: o_last_of_run});
    end

    // The run ends if no transfer happens for too long.
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int unsigned query_count;
        query_count = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_char_code  <= 8'h00;
        i_final_char <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every token kind but the error token, both extreme byte values and a comparison flushed at the end.
        query_text.delete();
        append_text("{?x>=<a>}");
        send_query();
        query_text.delete();
        append_text("!=(\"\"<= < 1.2)");
        send_query();
        query_text = '{8'h00, 8'hFF, CH_DOT, CH_EQ, CH_GT};
        send_query();

        // The sender holds off until every token so far has come out.
        drain_tokens();

        // Random queries, mostly well formed; some stretches run without idling.
        while (scoreboard.scanned_chars < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            query_count++;
            idle_enable = (query_count % 10) < 7;
            build_query();
            send_query();
        end

        // The last stretch runs with no idling on either side.
        idle_enable = 1'b0;
        while (scoreboard.scanned_chars < DIRECTED_ITEMS + RANDOM_ITEMS + QUIET_ITEMS) begin
            build_query();
            send_query();
        end

        drain_tokens();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (scoreboard.fail_count == 0 && scoreboard.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/qtt_pkg.sv
design/query_text_tokenizer.sv
design/qtt_checker.sv
verif/tb_top.sv
